[rtl/knh_pkg.sv]
// shared types, codes and constants of the k nearest candidate heap
package knh_pkg;

    // fixed field widths
    localparam int DIST_W  = 32;
    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 7;
    localparam int COUNT_W = 7;
    localparam int LIMIT_W = 7;

    // item commands
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_OFFER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // limit register after reset
    localparam logic [LIMIT_W-1:0] K_LIMIT_RESET = 7'd64;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_BLD_RD,
        S_BLD_LOAD,
        S_REP_START,
        S_SIFT,
        S_SIFT_END,
        S_DONE
    } t_state;

    // which addresses the two memory read ports take
    typedef enum logic [2:0] {
        RD_NONE,
        RD_K,
        RD_KIDS_K,
        RD_KIDS_ROOT,
        RD_KIDS_C,
        RD_SLOT
    } t_rd_sel;

    // commands from controller to datapath
    typedef struct packed {
        logic    latch_in;
        logic    do_start;
        logic    do_append;
        logic    set_acc;
        logic    set_ready;
        logic    k_init;
        logic    k_dec;
        logic    load_k;
        logic    load_new;
        logic    sift_step;
        logic    write_final;
        logic    load_out;
        t_rd_sel rd_sel;
    } t_dp_ctrl;

    // status from datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             below;
        logic             full;
        logic             heap_ready;
        logic             slot_ok;
        logic             half_zero;
        logic             has_kids_root;
        logic             move;
        logic             has_kids_c;
        logic             k_is_one;
        logic             rep;
    } t_dp_stat;

endpackage

[rtl/knh_if.sv]
// item channels and configuration write channel of the k nearest candidate heap

// query item channel
interface knh_in_if #(parameter int ID_BITS = 20);
    logic                        valid;
    logic                        ready;
    logic [knh_pkg::CMD_W-1:0]   command;
    logic [knh_pkg::DIST_W-1:0]  dist_sq;
    logic [ID_BITS-1:0]          candidate_id;
    logic [knh_pkg::SLOT_W-1:0]  read_slot;

    modport source (output valid, command, dist_sq, candidate_id, read_slot, input ready);
    modport sink   (input valid, command, dist_sq, candidate_id, read_slot, output ready);
endinterface

// result item channel
interface knh_out_if #(parameter int ID_BITS = 20);
    logic                        valid;
    logic                        ready;
    logic                        accepted;
    logic [knh_pkg::DIST_W-1:0]  radius_sq;
    logic [knh_pkg::COUNT_W-1:0] found_count;
    logic [knh_pkg::DIST_W-1:0]  slot_dist_sq;
    logic [ID_BITS-1:0]          slot_id;

    modport source (output valid, accepted, radius_sq, found_count, slot_dist_sq, slot_id,
                    input ready);
    modport sink   (input valid, accepted, radius_sq, found_count, slot_dist_sq, slot_id,
                    output ready);
endinterface

// limit register write channel
interface knh_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [knh_pkg::LIMIT_W-1:0] k_limit;

    modport source (output valid, k_limit, input ready);
    modport sink   (input valid, k_limit, output ready);
endinterface

[rtl/k_nearest_candidate_heap.sv]
// top level of the k nearest candidate heap
//
//  channel  | dir | handshake     | payload
//  i_in     | in  | valid / ready | command, dist_sq, candidate_id, read_slot
//  o_out    | out | valid / ready | accepted, radius_sq, found_count, slot_dist_sq, slot_id
//  i_cfg    | in  | valid / ready | k_limit (always ready)
//
// start, read, refused offer and append: the item passes S_DECODE and S_DONE, where the result is registered.
// replacing offer: S_DECODE, S_REP_START, S_SIFT for each heap level passed (one level per cycle,
// set by the single write port of the heap memory), S_SIFT_END if the bottom is reached, then S_DONE; the
// offer that first finds the list full adds a heap build of S_BLD_RD, S_BLD_LOAD and the sift per
// internal node.
// reset clears count, radius and flags; the heap memory needs no clearing pass.
// an item is taken while the previous result waits; a finished item holds until the
// output register is free.
module k_nearest_candidate_heap #(
    parameter int K_MAX   = 64,
    parameter int ID_BITS = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    knh_in_if.sink           i_in,
    knh_out_if.source        o_out,
    knh_cfg_if.sink          i_cfg
);
    import knh_pkg::*;

    t_dp_ctrl dp_ctrl;
    t_dp_stat dp_stat;
    logic     in_ready;
    logic     out_valid;

    // limit writes are always taken
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

    // sequencing
    knh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_stat      (dp_stat),
        .o_ctrl      (dp_ctrl)
    );

    // storage and compare
    knh_dp #(
        .K_MAX   (K_MAX),
        .ID_BITS (ID_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (dp_ctrl),
        .o_stat         (dp_stat),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_k_limit  (i_cfg.k_limit),
        .i_command      (i_in.command),
        .i_dist_sq      (i_in.dist_sq),
        .i_candidate_id (i_in.candidate_id),
        .i_read_slot    (i_in.read_slot),
        .o_accepted     (o_out.accepted),
        .o_radius_sq    (o_out.radius_sq),
        .o_found_count  (o_out.found_count),
        .o_slot_dist_sq (o_out.slot_dist_sq),
        .o_slot_id      (o_out.slot_id)
    );

endmodule

[rtl/knh_ctrl.sv]
// controller state machine of the k nearest candidate heap
module knh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  knh_pkg::t_dp_stat i_stat,
    output knh_pkg::t_dp_ctrl o_ctrl
);
    import knh_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // state and result valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state     = r_state;
        o_ctrl      = '0;
        o_ctrl.rd_sel = RD_NONE;
        o_in_ready  = 1'b0;
        n_out_valid = (r_out_valid && i_out_ready) ? 1'b0 : r_out_valid;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.latch_in = 1'b1;
                    n_state         = S_DECODE;
                end
            end

            S_DECODE: begin
                n_state = S_DONE;
                priority if (i_stat.cmd == CMD_START) begin
                    o_ctrl.do_start = 1'b1;
                end else if (i_stat.cmd == CMD_OFFER) begin
                    if (i_stat.below) begin
                        o_ctrl.set_acc = 1'b1;
                        priority if (!i_stat.full) begin
                            o_ctrl.do_append = 1'b1;
                        end else if (i_stat.heap_ready) begin
                            n_state = S_REP_START;
                        end else begin
                            // list just filled: build the heap first
                            o_ctrl.set_ready = 1'b1;
                            o_ctrl.k_init    = 1'b1;
                            n_state = i_stat.half_zero ? S_REP_START : S_BLD_RD;
                        end
                    end
                end else if (i_stat.cmd == CMD_READ) begin
                    if (i_stat.slot_ok) begin
                        o_ctrl.rd_sel = RD_SLOT;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end

            // fetch the node to sift during the build
            S_BLD_RD: begin
                o_ctrl.rd_sel = RD_K;
                n_state       = S_BLD_LOAD;
            end

            S_BLD_LOAD: begin
                o_ctrl.load_k = 1'b1;
                o_ctrl.rd_sel = RD_KIDS_K;
                n_state       = S_SIFT;
            end

            // new candidate takes the root
            S_REP_START: begin
                o_ctrl.load_new = 1'b1;
                o_ctrl.rd_sel   = RD_KIDS_ROOT;
                n_state = i_stat.has_kids_root ? S_SIFT : S_SIFT_END;
            end

            // one level of sift-down per cycle
            S_SIFT: begin
                o_ctrl.sift_step = 1'b1;
                if (i_stat.move) begin
                    o_ctrl.rd_sel = RD_KIDS_C;
                    n_state = i_stat.has_kids_c ? S_SIFT : S_SIFT_END;
                end else if (i_stat.rep) begin
                    n_state = S_DONE;
                end else begin
                    o_ctrl.k_dec = 1'b1;
                    n_state = i_stat.k_is_one ? S_REP_START : S_BLD_RD;
                end
            end

            S_SIFT_END: begin
                o_ctrl.write_final = 1'b1;
                if (i_stat.rep) begin
                    n_state = S_DONE;
                end else begin
                    o_ctrl.k_dec = 1'b1;
                    n_state = i_stat.k_is_one ? S_REP_START : S_BLD_RD;
                end
            end

            // hand the result to the output register
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_ctrl.load_out = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/knh_dp.sv]
// datapath of the k nearest candidate heap: item latch, heap memory, sift unit, result register
module knh_dp #(
    parameter int K_MAX   = 64,
    parameter int ID_BITS = 20
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  knh_pkg::t_dp_ctrl            i_ctrl,
    output knh_pkg::t_dp_stat            o_stat,
    input  logic                         i_cfg_we,
    input  logic [knh_pkg::LIMIT_W-1:0]  i_cfg_k_limit,
    input  logic [knh_pkg::CMD_W-1:0]    i_command,
    input  logic [knh_pkg::DIST_W-1:0]   i_dist_sq,
    input  logic [ID_BITS-1:0]           i_candidate_id,
    input  logic [knh_pkg::SLOT_W-1:0]   i_read_slot,
    output logic                         o_accepted,
    output logic [knh_pkg::DIST_W-1:0]   o_radius_sq,
    output logic [knh_pkg::COUNT_W-1:0]  o_found_count,
    output logic [knh_pkg::DIST_W-1:0]   o_slot_dist_sq,
    output logic [ID_BITS-1:0]           o_slot_id
);
    import knh_pkg::*;

    localparam int CW   = $clog2(K_MAX + 1);
    localparam int SW   = CW + 1;
    localparam int AW   = $clog2(K_MAX);
    localparam int MW   = DIST_W + ID_BITS;
    localparam int CMPW = (CW > SLOT_W) ? CW : SLOT_W;

    // heap storage, slot s at address s-1, entry is {dist, id}
    logic [MW-1:0] mem [K_MAX];

    logic [CMD_W-1:0]   r_cmd;
    logic [DIST_W-1:0]  r_dist;
    logic [ID_BITS-1:0] r_id;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_acc;
    logic [DIST_W-1:0]  r_radius;
    logic [CW-1:0]      r_held;
    logic               r_ready;
    logic [LIMIT_W-1:0] r_k_limit;
    logic [CW-1:0]      r_k;
    logic [CW-1:0]      r_pos;
    logic [DIST_W-1:0]  r_d;
    logic [ID_BITS-1:0] r_did;
    logic               r_rep;
    logic [MW-1:0]      r_rd_a;
    logic [MW-1:0]      r_rd_b;

    logic [CMPW-1:0]    held_x;
    logic [CMPW-1:0]    lim_x;
    logic [CMPW-1:0]    eff_lim;
    logic               slot_ok;
    logic [SW-1:0]      n_sw;
    logic [SW-1:0]      kids_pos;
    logic [SW-1:0]      kids_k;
    logic [SW-1:0]      kids_c;
    logic [DIST_W-1:0]  a_dist;
    logic [DIST_W-1:0]  b_dist;
    logic               pick_b;
    logic [SW-1:0]      c_sw;
    logic [CW-1:0]      c_cw;
    logic [MW-1:0]      child;
    logic               move;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [MW-1:0]      wdata;
    logic               rd_en;
    logic [AW-1:0]      raddr_a;
    logic [AW-1:0]      raddr_b;

    // limit clamp and list status
    always_comb begin
        held_x  = CMPW'(r_held);
        lim_x   = (r_k_limit == '0) ? CMPW'(1) : CMPW'(r_k_limit);
        eff_lim = (lim_x > CMPW'(K_MAX)) ? CMPW'(K_MAX) : lim_x;
        slot_ok = (r_slot != '0) && (CMPW'(r_slot) <= held_x);
    end

    // sift step: pick the larger child and decide whether the element moves down
    always_comb begin
        n_sw     = SW'(r_held);
        kids_pos = {r_pos, 1'b0};
        kids_k   = {r_k, 1'b0};
        a_dist   = r_rd_a[MW-1 -: DIST_W];
        b_dist   = r_rd_b[MW-1 -: DIST_W];
        pick_b   = (kids_pos < n_sw) && (a_dist < b_dist);
        c_sw     = kids_pos + SW'(pick_b);
        c_cw     = c_sw[CW-1:0];
        kids_c   = {c_cw, 1'b0};
        child    = pick_b ? r_rd_b : r_rd_a;
        // ties: build stops at an equal child, replacement passes it
        move     = r_rep ? (r_d <= child[MW-1 -: DIST_W]) : (r_d < child[MW-1 -: DIST_W]);
    end

    // status to the controller
    always_comb begin
        o_stat.cmd           = r_cmd;
        o_stat.below         = r_dist < r_radius;
        o_stat.full          = held_x >= eff_lim;
        o_stat.heap_ready    = r_ready;
        o_stat.slot_ok       = slot_ok;
        o_stat.half_zero     = (r_held >> 1) == '0;
        o_stat.has_kids_root = n_sw >= SW'(2);
        o_stat.move          = move;
        o_stat.has_kids_c    = kids_c <= n_sw;
        o_stat.k_is_one      = r_k == CW'(1);
        o_stat.rep           = r_rep;
    end

    // memory write port
    always_comb begin
        we    = i_ctrl.do_append || i_ctrl.sift_step || i_ctrl.write_final;
        waddr = AW'(r_pos - CW'(1));
        wdata = {r_d, r_did};
        if (i_ctrl.do_append) begin
            waddr = AW'(r_held);
            wdata = {r_dist, r_id};
        end else if (i_ctrl.sift_step && move) begin
            wdata = child;
        end
    end

    // memory read ports
    always_comb begin
        rd_en   = i_ctrl.rd_sel != RD_NONE;
        raddr_a = '0;
        raddr_b = '0;
        unique case (i_ctrl.rd_sel)
            RD_K: begin
                raddr_a = AW'(r_k - CW'(1));
            end
            RD_KIDS_K: begin
                raddr_a = AW'(kids_k - SW'(1));
                raddr_b = AW'(kids_k);
            end
            RD_KIDS_ROOT: begin
                raddr_a = AW'(1);
                raddr_b = AW'(2);
            end
            RD_KIDS_C: begin
                raddr_a = AW'(kids_c - SW'(1));
                raddr_b = AW'(kids_c);
            end
            RD_SLOT: begin
                raddr_a = AW'(CMPW'(r_slot) - CMPW'(1));
            end
            default: begin
                raddr_a = '0;
            end
        endcase
    end

    // heap memory
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_a <= mem[raddr_a];
            r_rd_b <= mem[raddr_b];
        end
    end

    // control state of the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= '0;
            r_held    <= '0;
            r_ready   <= 1'b0;
            r_k_limit <= K_LIMIT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_k_limit <= i_cfg_k_limit;
            end
            if (i_ctrl.do_start) begin
                r_held   <= '0;
                r_ready  <= 1'b0;
                r_radius <= r_dist;
            end
            if (i_ctrl.do_append) begin
                r_held <= r_held + CW'(1);
            end
            if (i_ctrl.set_ready) begin
                r_ready <= 1'b1;
            end
            // the root written during a replacement becomes the radius
            if (we && !i_ctrl.do_append && r_rep && (r_pos == CW'(1))) begin
                r_radius <= wdata[MW-1 -: DIST_W];
            end
        end
    end

    // item latch and sift registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.latch_in) begin
            r_cmd  <= i_command;
            r_dist <= i_dist_sq;
            r_id   <= i_candidate_id;
            r_slot <= i_read_slot;
            r_acc  <= 1'b0;
        end
        if (i_ctrl.set_acc) begin
            r_acc <= 1'b1;
        end
        if (i_ctrl.k_init) begin
            r_k <= r_held >> 1;
        end
        if (i_ctrl.k_dec) begin
            r_k <= r_k - CW'(1);
        end
        if (i_ctrl.load_k) begin
            r_d   <= r_rd_a[MW-1 -: DIST_W];
            r_did <= r_rd_a[ID_BITS-1:0];
            r_pos <= r_k;
            r_rep <= 1'b0;
        end
        if (i_ctrl.load_new) begin
            r_d   <= r_dist;
            r_did <= r_id;
            r_pos <= CW'(1);
            r_rep <= 1'b1;
        end
        if (i_ctrl.sift_step && move) begin
            r_pos <= c_cw;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_out) begin
            o_accepted    <= r_acc;
            o_radius_sq   <= r_radius;
            o_found_count <= held_x[COUNT_W-1:0];
            if ((r_cmd == CMD_READ) && slot_ok) begin
                o_slot_dist_sq <= r_rd_a[MW-1 -: DIST_W];
                o_slot_id      <= r_rd_a[ID_BITS-1:0];
            end else begin
                o_slot_dist_sq <= '0;
                o_slot_id      <= '0;
            end
        end
    end

endmodule
